// ----- hw/rtl/slav_pkg.sv -----
// Shared constants, codes and control types of the saw/lowpass/ADSR voice.
package slav_pkg;

  localparam int SUSTAIN_SAMPLES_DEF = 11025;
  localparam int SAMPLE_BITS_DEF     = 16;

  localparam int PH_W       = 32;
  localparam int COEF_W     = 32;
  localparam int LEN_W      = 24;
  localparam int LVL_W      = 17;
  localparam int IDX_W      = 26;
  localparam int ST_W       = 40;
  localparam int ACC_W      = 72;
  localparam int MA_W       = 32;
  localparam int MB_W       = 25;
  localparam int Q_W        = 17;
  localparam int SEGT_W     = 27;
  localparam int SATIN_W    = 44;
  localparam int CNT_W      = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [LVL_W-1:0] ENV_ONE = LVL_W'(65536);
  localparam logic [IDX_W-1:0] IDX_MAX = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PHASE_INC = 3'd0,
    REG_COEF_B0   = 3'd1,
    REG_COEF_A1   = 3'd2,
    REG_COEF_A2   = 3'd3,
    REG_ATTACK    = 3'd4,
    REG_DECAY     = 3'd5,
    REG_SUSTAIN   = 3'd6,
    REG_RELEASE   = 3'd7
  } cfg_reg_t;

  typedef enum logic [2:0] {
    SEG_ATK = 3'd0,
    SEG_DEC = 3'd1,
    SEG_SUS = 3'd2,
    SEG_REL = 3'd3,
    SEG_OFF = 3'd4
  } seg_t;

  typedef enum logic [2:0] {
    MA_NUM = 3'd0,
    MA_B0  = 3'd1,
    MA_A1  = 3'd2,
    MA_A2  = 3'd3,
    MA_ENV = 3'd4
  } mul_a_sel_t;

  typedef enum logic [2:0] {
    MB_NUM = 3'd0,
    MB_XHI = 3'd1,
    MB_XLO = 3'd2,
    MB_YHI = 3'd3,
    MB_YLO = 3'd4
  } mul_b_sel_t;

  typedef struct packed {
    logic       accept;
    logic       seg;
    logic       div_init;
    logic       div_step;
    logic       env;
    logic       mul_en;
    logic       mul_clr;
    logic       mul_sh;
    mul_a_sel_t msel_a;
    mul_b_sel_t msel_b;
    logic       y_ld;
    logic       s1_upd;
    logic       s2_upd;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } stat_t;

  // clamp to 40-bit signed
  function automatic logic signed [ST_W-1:0] sat_st(input logic signed [SATIN_W-1:0] v);
    logic signed [ST_W-1:0] r;
    if (v[SATIN_W-1:ST_W-1] == '0 || v[SATIN_W-1:ST_W-1] == '1) begin
      r = v[ST_W-1:0];
    end else if (v[SATIN_W-1]) begin
      r = {1'b1, {(ST_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(ST_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/slav_if.sv -----
// Request and result channel interfaces of the voice.
interface slav_in_if;
  logic valid;
  logic ready;
  logic opcode;
  logic last_tick;
  modport source (output valid, output opcode, output last_tick, input ready);
  modport sink (input valid, input opcode, input last_tick, output ready);
endinterface

interface slav_out_if import slav_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          last;
  modport source (output valid, output sample, output last, input ready);
  modport sink (input valid, input sample, input last, output ready);
endinterface

// ----- hw/rtl/saw_lowpass_adsr_voice.sv -----
// Channel    | Dir | Payload                    | Handshake
// in_ch      | in  | opcode, last_tick          | valid/ready
// out_ch     | out | sample (SAMPLE_BITS), last | valid/ready
// cfg_*      | in  | cfg_idx, cfg_wdata         | cfg_we, no wait
// Each request runs the one-bit-per-cycle envelope divider and nine passes
// of the shared 32x25 multiplier-accumulator before its result is loaded;
// a new request is accepted only after that load. Synchronous reset loads
// register defaults and zeros the voice state; no clearing pass. A result
// sits in the output register so the next request is taken while it waits;
// a request finishing before that result is taken holds in its last step.
module saw_lowpass_adsr_voice import slav_pkg::*; #(
  parameter int SUSTAIN_SAMPLES = SUSTAIN_SAMPLES_DEF,
  parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  slav_in_if.sink               in_ch,
  slav_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cmd_t  cmd;
  stat_t stat;

  slav_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  slav_dp #(
    .SUSTAIN_SAMPLES (SUSTAIN_SAMPLES),
    .SAMPLE_BITS     (SAMPLE_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_idx      (cfg_idx),
    .cfg_wdata    (cfg_wdata),
    .in_opcode    (in_ch.opcode),
    .in_last_tick (in_ch.last_tick),
    .cmd          (cmd),
    .stat         (stat),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_sample   (out_ch.sample),
    .out_last     (out_ch.last)
  );

endmodule

// ----- hw/rtl/slav_ctrl.sv -----
// Sequencer: steps the datapath through envelope, divider and filter passes.
module slav_ctrl import slav_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [15:0] {
    S_IDLE = 16'h0001,
    S_SEG  = 16'h0002,
    S_NUM  = 16'h0004,
    S_DIVI = 16'h0008,
    S_DIV  = 16'h0010,
    S_ENV  = 16'h0020,
    S_P0   = 16'h0040,
    S_P1   = 16'h0080,
    S_Y    = 16'h0100,
    S_A1H  = 16'h0200,
    S_A1L  = 16'h0400,
    S_A2H  = 16'h0800,
    S_A2L  = 16'h1000,
    S_EH   = 16'h2000,
    S_EL   = 16'h4000,
    S_OUT  = 16'h8000
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid) state_nxt = S_SEG;
      end
      S_SEG: begin
        cmd.seg   = 1'b1;
        state_nxt = S_NUM;
      end
      S_NUM: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_clr = 1'b1;
        cmd.msel_a  = MA_NUM;
        cmd.msel_b  = MB_NUM;
        state_nxt   = S_DIVI;
      end
      S_DIVI: begin
        cmd.div_init = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(Q_W - 1)) state_nxt = S_ENV;
      end
      S_ENV: begin
        cmd.env   = 1'b1;
        state_nxt = S_P0;
      end
      S_P0: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_clr = 1'b1;
        cmd.mul_sh  = 1'b1;
        cmd.msel_a  = MA_B0;
        cmd.msel_b  = MB_XHI;
        state_nxt   = S_P1;
      end
      S_P1: begin
        cmd.mul_en = 1'b1;
        cmd.msel_a = MA_B0;
        cmd.msel_b = MB_XLO;
        state_nxt  = S_Y;
      end
      S_Y: begin
        cmd.y_ld  = 1'b1;
        state_nxt = S_A1H;
      end
      S_A1H: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_clr = 1'b1;
        cmd.mul_sh  = 1'b1;
        cmd.msel_a  = MA_A1;
        cmd.msel_b  = MB_YHI;
        state_nxt   = S_A1L;
      end
      S_A1L: begin
        cmd.mul_en = 1'b1;
        cmd.msel_a = MA_A1;
        cmd.msel_b = MB_YLO;
        state_nxt  = S_A2H;
      end
      S_A2H: begin
        cmd.s1_upd  = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_clr = 1'b1;
        cmd.mul_sh  = 1'b1;
        cmd.msel_a  = MA_A2;
        cmd.msel_b  = MB_YHI;
        state_nxt   = S_A2L;
      end
      S_A2L: begin
        cmd.mul_en = 1'b1;
        cmd.msel_a = MA_A2;
        cmd.msel_b = MB_YLO;
        state_nxt  = S_EH;
      end
      S_EH: begin
        cmd.s2_upd  = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_clr = 1'b1;
        cmd.mul_sh  = 1'b1;
        cmd.msel_a  = MA_ENV;
        cmd.msel_b  = MB_YHI;
        state_nxt   = S_EL;
      end
      S_EL: begin
        cmd.mul_en = 1'b1;
        cmd.msel_a = MA_ENV;
        cmd.msel_b = MB_YLO;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        // hold here while the previous result is still unclaimed
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_SEG))
    else $error("accepted request did not start the envelope step");

  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (cnt_r < CNT_W'(Q_W)))
    else $error("divider ran past its quotient width");

  a_load_gate: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> stat.out_free)
    else $error("result loaded over an unclaimed result");

  a_div_to_env: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ENV) |-> ($past(state_r) == S_DIV))
    else $error("envelope latched without a finished divide");

endmodule

// ----- hw/rtl/slav_dp.sv -----
// Datapath: config registers, voice state, shared multiplier/accumulator, divider.
module slav_dp import slav_pkg::*; #(
  parameter int SUSTAIN_SAMPLES = SUSTAIN_SAMPLES_DEF,
  parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_idx,
  input  logic [CFG_DATA_W-1:0]         cfg_wdata,
  input  logic                          in_opcode,
  input  logic                          in_last_tick,
  input  cmd_t                          cmd,
  output stat_t                         stat,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_sample,
  output logic                          out_last
);

  localparam int OUT_SHIFT = 48 - SAMPLE_BITS;
  localparam logic signed [ACC_W-1:0] RND    = ACC_W'(1) << (OUT_SHIFT - 1);
  localparam logic signed [ACC_W-1:0] LIM_HI = (ACC_W'(1) << (SAMPLE_BITS - 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] LIM_LO = -LIM_HI - ACC_W'(1);

  // configuration
  logic        [PH_W-1:0]   inc_r;
  logic signed [COEF_W-1:0] b0_r, a1_r, a2_r;
  logic        [LEN_W-1:0]  att_r, dec_r, rel_r;
  logic        [LVL_W-1:0]  sus_r;

  // voice state
  logic        [PH_W-1:0]  phase_r;
  logic signed [ST_W-1:0]  s1_r, s2_r;
  logic        [IDX_W-1:0] idx_r;

  // working registers
  logic                      last_r;
  seg_t                      seg_r;
  logic        [LVL_W-1:0]   num_a_r;
  logic        [LEN_W-1:0]   num_b_r;
  logic        [LEN_W-1:0]   den_r;
  logic        [LEN_W-1:0]   rem_r;
  logic        [Q_W-1:0]     q_r;
  logic        [LVL_W-1:0]   env_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [34:0]        p29_r;
  logic signed [ST_W-1:0]    y_r;
  logic                      out_valid_r;
  logic signed [SAMPLE_BITS-1:0] sample_r;
  logic                      olast_r;

  // envelope segment decode
  logic [LVL_W-1:0]  s_cl;
  logic [SEGT_W-1:0] t_x, de, se, u;
  seg_t              seg_nxt;
  logic [LVL_W-1:0]  num_a_nxt;
  logic [LEN_W-1:0]  num_b_nxt, den_nxt;

  always_comb begin
    s_cl      = (sus_r > ENV_ONE) ? ENV_ONE : sus_r;
    t_x       = SEGT_W'(idx_r);
    de        = SEGT_W'(att_r) + SEGT_W'(dec_r);
    se        = de + SEGT_W'(SUSTAIN_SAMPLES);
    u         = t_x - se;
    seg_nxt   = SEG_OFF;
    num_a_nxt = s_cl;
    num_b_nxt = '0;
    den_nxt   = rel_r;
    priority if (t_x < SEGT_W'(att_r)) begin
      seg_nxt   = SEG_ATK;
      num_a_nxt = ENV_ONE;
      num_b_nxt = t_x[LEN_W-1:0];
      den_nxt   = att_r;
    end else if (t_x < de) begin
      seg_nxt   = SEG_DEC;
      num_a_nxt = ENV_ONE - s_cl;
      num_b_nxt = t_x[LEN_W-1:0] - att_r;
      den_nxt   = dec_r;
    end else if (t_x < se) begin
      seg_nxt = SEG_SUS;
    end else if (u >= SEGT_W'(rel_r)) begin
      seg_nxt = SEG_OFF;
    end else begin
      seg_nxt   = SEG_REL;
      num_b_nxt = rel_r - u[LEN_W-1:0];
    end
  end

  // shared multiplier and accumulator
  logic signed [MA_W-1:0]      ma;
  logic signed [MB_W-1:0]      mb;
  logic signed [MA_W+MB_W-1:0] prod;
  logic signed [ACC_W-1:0]     prod_x, addend, acc_nxt;

  always_comb begin
    unique case (cmd.msel_a)
      MA_NUM:  ma = MA_W'(num_a_r);
      MA_B0:   ma = b0_r;
      MA_A1:   ma = a1_r;
      MA_A2:   ma = a2_r;
      MA_ENV:  ma = MA_W'(env_r);
      default: ma = '0;
    endcase
    unique case (cmd.msel_b)
      MB_NUM:  mb = MB_W'(num_b_r);
      MB_XHI:  mb = {{(MB_W-16){phase_r[PH_W-1]}}, phase_r[PH_W-1:16]};
      MB_XLO:  mb = MB_W'(phase_r[15:0]);
      MB_YHI:  mb = {y_r[ST_W-1], y_r[ST_W-1:16]};
      MB_YLO:  mb = MB_W'(y_r[15:0]);
      default: mb = '0;
    endcase
    prod    = ma * mb;
    prod_x  = {{(ACC_W-MA_W-MB_W){prod[MA_W+MB_W-1]}}, prod};
    addend  = cmd.mul_sh ? (prod_x <<< 16) : prod_x;
    acc_nxt = cmd.mul_clr ? addend : acc_r + addend;
  end

  // divider step
  logic [LEN_W:0]   trial;
  logic             ge;
  logic [LEN_W-1:0] rem_nxt;

  always_comb begin
    trial   = {rem_r, q_r[Q_W-1]};
    ge      = trial >= {1'b0, den_r};
    rem_nxt = ge ? LEN_W'(trial - {1'b0, den_r}) : trial[LEN_W-1:0];
  end

  // filter arithmetic
  logic signed [SATIN_W-1:0] y_sum, s1_sum, s2_sum;
  logic signed [ACC_W-1:0]   m_acc;

  always_comb begin
    m_acc  = acc_r >>> 30;
    y_sum  = SATIN_W'(acc_r >>> 30) + SATIN_W'(s1_r);
    s1_sum = SATIN_W'(p29_r) + SATIN_W'(s2_r) - SATIN_W'(m_acc);
    s2_sum = SATIN_W'(p29_r >>> 1) - SATIN_W'(m_acc);
  end

  // output rounding and saturation
  logic signed [ACC_W-1:0]       rnd_q;
  logic signed [SAMPLE_BITS-1:0] sample_nxt;

  always_comb begin
    rnd_q = (acc_r + RND) >>> OUT_SHIFT;
    priority if (rnd_q > LIM_HI) begin
      sample_nxt = LIM_HI[SAMPLE_BITS-1:0];
    end else if (rnd_q < LIM_LO) begin
      sample_nxt = LIM_LO[SAMPLE_BITS-1:0];
    end else begin
      sample_nxt = rnd_q[SAMPLE_BITS-1:0];
    end
  end

  // control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inc_r       <= '0;
      b0_r        <= '0;
      a1_r        <= '0;
      a2_r        <= '0;
      att_r       <= LEN_W'(1);
      dec_r       <= '0;
      sus_r       <= ENV_ONE;
      rel_r       <= LEN_W'(1);
      phase_r     <= '0;
      s1_r        <= '0;
      s2_r        <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_idx))
          REG_PHASE_INC: inc_r <= cfg_wdata[PH_W-1:0];
          REG_COEF_B0:   b0_r  <= cfg_wdata[COEF_W-1:0];
          REG_COEF_A1:   a1_r  <= cfg_wdata[COEF_W-1:0];
          REG_COEF_A2:   a2_r  <= cfg_wdata[COEF_W-1:0];
          REG_ATTACK:    att_r <= cfg_wdata[LEN_W-1:0];
          REG_DECAY:     dec_r <= cfg_wdata[LEN_W-1:0];
          REG_SUSTAIN:   sus_r <= cfg_wdata[LVL_W-1:0];
          REG_RELEASE:   rel_r <= cfg_wdata[LEN_W-1:0];
        endcase
      end
      if (cmd.accept) begin
        if (in_opcode) begin
          phase_r <= inc_r;
          s1_r    <= '0;
          s2_r    <= '0;
          idx_r   <= '0;
        end else begin
          phase_r <= phase_r + inc_r;
        end
      end
      if (cmd.s1_upd) s1_r <= sat_st(s1_sum);
      if (cmd.s2_upd) s2_r <= sat_st(s2_sum);
      if (cmd.out_load) begin
        if (idx_r != IDX_MAX) idx_r <= idx_r + IDX_W'(1);
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // working payload
  always_ff @(posedge clk) begin
    if (cmd.accept) last_r <= in_last_tick;
    if (cmd.seg) begin
      seg_r   <= seg_nxt;
      num_a_r <= num_a_nxt;
      num_b_r <= num_b_nxt;
      den_r   <= den_nxt;
    end
    if (cmd.mul_en) acc_r <= acc_nxt;
    if (cmd.div_init) begin
      // quotient fits 17 bits, so the top part is already below the divisor
      rem_r <= acc_r[Q_W+LEN_W-1:Q_W];
      q_r   <= acc_r[Q_W-1:0];
    end else if (cmd.div_step) begin
      rem_r <= rem_nxt;
      q_r   <= {q_r[Q_W-2:0], ge};
    end
    if (cmd.env) begin
      unique case (seg_r)
        SEG_ATK: env_r <= q_r;
        SEG_DEC: env_r <= ENV_ONE - q_r;
        SEG_SUS: env_r <= s_cl;
        SEG_REL: env_r <= q_r;
        default: env_r <= '0;
      endcase
    end
    if (cmd.y_ld) begin
      p29_r <= 35'(acc_r >>> 29);
      y_r   <= sat_st(y_sum);
    end
    if (cmd.out_load) begin
      sample_r <= sample_nxt;
      olast_r  <= last_r;
    end
  end

  assign stat.out_free = !out_valid_r || out_ready;
  assign out_valid     = out_valid_r;
  assign out_sample    = sample_r;
  assign out_last      = olast_r;

  a_env_range: assert property (@(posedge clk) disable iff (!rst_n)
    $past(cmd.env) |-> (env_r <= ENV_ONE))
    else $error("envelope above full scale");

  a_idx_start: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.accept && in_opcode) |=> (idx_r == '0))
    else $error("note start did not clear the sample index");

  a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.out_load && idx_r != IDX_MAX) |=> (idx_r == $past(idx_r) + IDX_W'(1)))
    else $error("sample index did not advance with the result");

endmodule
